// ----- rtl/vnd_pkg.sv -----
package vnd_pkg;

   localparam int LANES = 4;

   typedef enum logic [2:0] {
      FN_LENGTH      = 3'd0,
      FN_LENGTH_SQ   = 3'd1,
      FN_DISTANCE    = 3'd2,
      FN_DISTANCE_SQ = 3'd3,
      FN_DOT         = 3'd4,
      FN_NORMALISE   = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_ZERO = 2'd2
   } status_type;

endpackage

// ----- rtl/vnd_lane.sv -----
// One vector component: magnitudes, then squares and the dot product term.
module vnd_lane #(
   parameter int CW = 32
) (
   input  logic                 clock,
   input  logic                 adv,
   input  logic signed [CW-1:0] a_in,
   input  logic signed [CW-1:0] b_in,
   output logic [2*CW-1:0]      sqa,
   output logic [2*CW+1:0]      sqd,
   output logic [2*CW-1:0]      prod,
   output logic                 prod_neg,
   output logic [CW-1:0]        mag_a,
   output logic                 neg_a
);

   logic [CW-1:0]        ma1_ff, ma1_in, mb1_ff, mb1_in;
   logic [CW:0]          md1_ff, md1_in;
   logic                 nega1_ff, pneg1_ff;
   logic signed [CW:0]   diff;
   logic [2*CW-1:0]      sqa2_ff, prod2_ff;
   logic [2*CW+1:0]      sqd2_ff;
   logic                 pneg2_ff, nega2_ff;
   logic [CW-1:0]        ma2_ff;

   assign diff   = {a_in[CW-1], a_in} - {b_in[CW-1], b_in};
   assign ma1_in = a_in[CW-1] ? (~a_in + 1'b1) : a_in;
   assign mb1_in = b_in[CW-1] ? (~b_in + 1'b1) : b_in;
   assign md1_in = diff[CW] ? (~diff + 1'b1) : diff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ma1_ff   <= ma1_in;
         mb1_ff   <= mb1_in;
         md1_ff   <= md1_in;
         nega1_ff <= a_in[CW-1];
         pneg1_ff <= a_in[CW-1] ^ b_in[CW-1];
         sqa2_ff  <= ma1_ff * ma1_ff;
         sqd2_ff  <= md1_ff * md1_ff;
         prod2_ff <= ma1_ff * mb1_ff;
         pneg2_ff <= pneg1_ff;
         nega2_ff <= nega1_ff;
         ma2_ff   <= ma1_ff;
      end
   end

   assign sqa      = sqa2_ff;
   assign sqd      = sqd2_ff;
   assign prod     = prod2_ff;
   assign prod_neg = pneg2_ff;
   assign mag_a    = ma2_ff;
   assign neg_a    = nega2_ff;

endmodule

// ----- rtl/vnd_sqrt.sv -----
// Pipelined floor square root, one result bit per stage.
module vnd_sqrt #(
   parameter int SW     = 68,
   parameter int RW     = 34,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [SW-1:0]     in_sum,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [RW-1:0]     out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic [SW-1:0]     rem_ff  [0:RW-1];
   logic [RW-1:0]     root_ff [1:RW];
   logic [SIDE_W-1:0] side_ff [0:RW];
   logic [RW:0]       vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[RW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= in_sum;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < RW; k++) begin : g_stg
      localparam int B = RW - 1 - k;
      logic [RW-1:0] root_prev;
      logic [SW-1:0] trial;
      logic          ge;

      if (k == 0) begin : g_first
         assign root_prev = '0;
      end else begin : g_next
         assign root_prev = root_ff[k];
      end

      // (r + 2^B)^2 - r^2
      assign trial = (SW'(root_prev) << (B + 1)) + (SW'(1) << (2 * B));
      assign ge    = rem_ff[k] >= trial;

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[k+1] <= ge ? (root_prev | (RW'(1) << B)) : root_prev;
            side_ff[k+1] <= side_ff[k];
         end
      end

      if (k < RW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k+1] <= ge ? (rem_ff[k] - trial) : rem_ff[k];
            end
         end
      end
   end

   assign out_valid = vld_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_side  = side_ff[RW];

endmodule

// ----- rtl/vnd_div.sv -----
// Pipelined restoring divide of mag * 2^FB by len, one quotient bit per stage.
// Only the low FB+1 quotient bits are formed since mag <= len.
module vnd_div #(
   parameter int RW   = 34,
   parameter int MAGW = 32,
   parameter int FB   = 16
) (
   input  logic            clock,
   input  logic            adv,
   input  logic [MAGW-1:0] in_mag,
   input  logic [RW-1:0]   in_len,
   output logic [FB:0]     out_q
);

   localparam int QW  = FB + 1;
   localparam int RMW = RW + 1;

   logic [RMW-1:0] rem_ff [0:QW-1];
   logic [RW-1:0]  len_ff [0:QW-1];
   logic [QW-1:0]  q_ff   [1:QW];
   logic           nb_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= RMW'(in_mag >> 1);
         nb_ff     <= in_mag[0];
         len_ff[0] <= in_len;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_stg
      logic [QW-1:0]  q_prev;
      logic [RMW-1:0] shifted;
      logic           nbit;
      logic           ge;

      if (k == 0) begin : g_first
         assign q_prev = '0;
         assign nbit   = nb_ff;
      end else begin : g_next
         assign q_prev = q_ff[k];
         assign nbit   = 1'b0;
      end

      assign shifted = {rem_ff[k][RW-1:0], nbit};
      assign ge      = shifted >= {1'b0, len_ff[k]};

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[k+1] <= {q_prev[QW-2:0], ge};
         end
      end

      if (k < QW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k+1] <= ge ? (shifted - {1'b0, len_ff[k]}) : shifted;
               len_ff[k+1] <= len_ff[k];
            end
         end
      end
   end

   assign out_q = q_ff[QW];

endmodule

// ----- rtl/vec4_norm_dot_normalise.sv -----
// Four-component vector unit in signed fixed point (Q16.16 by default).
// Input channel req_*: an operation code and two vectors; output channel rsp_*:
// one transaction per request with a saturated scalar, a normalized vector and
// a status code. Codes 6 and 7 return all zeros with status ok.
// Every request travels the same fully pipelined path, one transaction per
// cycle sustained while the output is not stalled: magnitude and multiply
// lanes, merge and sum, square root (one root bit per stage), per-lane
// division, and the output register.
// When rsp_ready is low with a result held, the whole pipeline freezes and
// req_ready drops in the same cycle; no transaction is lost or repeated.
// Synchronous reset clears all valid flags; other state is not reset.
module vec4_norm_dot_normalise #(
   parameter int COMPONENT_WIDTH = 32,
   parameter int FRAC_BITS       = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_func,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_w,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_w,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_scalar_out,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_x,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_y,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_z,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_w,
   output logic [1:0]                        rsp_status
);

   import vnd_pkg::*;

   localparam int CW   = COMPONENT_WIDTH;
   localparam int FB   = FRAC_BITS;
   localparam int SW   = 2 * CW + 4;
   localparam int RW   = CW + 2;
   localparam int PSW  = 2 * CW + 2;
   localparam int DW   = PSW + 1;
   localparam int QW   = FB + 1;
   localparam int CMPW = CW + QW;
   localparam int SIDE_W = 3 + CW + 2 + LANES * CW + LANES;
   localparam int LINE_W = 3 + CW + 2 + LANES + RW;
   localparam int DLAT   = FB + 2;

   localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] NEG_MIN = {1'b1, {(CW-1){1'b0}}};

   logic adv;

   // ---------------- lanes ----------------
   logic signed [CW-1:0] a_arr [LANES];
   logic signed [CW-1:0] b_arr [LANES];
   logic [2*CW-1:0]      sqa   [LANES];
   logic [2*CW+1:0]      sqd   [LANES];
   logic [2*CW-1:0]      prod  [LANES];
   logic [CW-1:0]        mag_a [LANES];
   logic [LANES-1:0]     prod_neg, neg_a;

   assign a_arr[0] = req_a_x;
   assign a_arr[1] = req_a_y;
   assign a_arr[2] = req_a_z;
   assign a_arr[3] = req_a_w;
   assign b_arr[0] = req_b_x;
   assign b_arr[1] = req_b_y;
   assign b_arr[2] = req_b_z;
   assign b_arr[3] = req_b_w;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      vnd_lane #(.CW(CW)) u_lane (
         .clock    (clock),
         .adv      (adv),
         .a_in     (a_arr[i]),
         .b_in     (b_arr[i]),
         .sqa      (sqa[i]),
         .sqd      (sqd[i]),
         .prod     (prod[i]),
         .prod_neg (prod_neg[i]),
         .mag_a    (mag_a[i]),
         .neg_a    (neg_a[i])
      );
   end

   logic [1:0]     v12_ff;
   logic [2:0]     f1_ff, f2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v12_ff <= '0;
      end else if (adv) begin
         v12_ff <= {v12_ff[0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff <= req_func;
         f2_ff <= f1_ff;
      end
   end

   // ---------------- merge ----------------
   logic [SW-1:0]  sum3_in, sum3_ff, sum4_ff;
   logic [PSW-1:0] pos3_in, neg3_in, pos3_ff, neg3_ff;
   logic           use_diff;
   logic [CW-1:0]  ma3_ff [LANES];
   logic [CW-1:0]  ma4_ff [LANES];
   logic [LANES-1:0] nega3_ff, nega4_ff;
   logic [2:0]     f3_ff, f4_ff;
   logic           v3_ff, v4_ff;
   logic signed [DW-1:0] diff4_ff;

   assign use_diff = (func_type'(f2_ff) == FN_DISTANCE) ||
                     (func_type'(f2_ff) == FN_DISTANCE_SQ);

   always_comb begin
      sum3_in = '0;
      pos3_in = '0;
      neg3_in = '0;
      for (int i = 0; i < LANES; i++) begin
         sum3_in = sum3_in + (use_diff ? SW'(sqd[i]) : SW'(sqa[i]));
         if (prod_neg[i]) begin
            neg3_in = neg3_in + PSW'(prod[i]);
         end else begin
            pos3_in = pos3_in + PSW'(prod[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v12_ff[1];
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum3_ff  <= sum3_in;
         pos3_ff  <= pos3_in;
         neg3_ff  <= neg3_in;
         ma3_ff   <= mag_a;
         nega3_ff <= neg_a;
         f3_ff    <= f2_ff;
         sum4_ff  <= sum3_ff;
         diff4_ff <= $signed({1'b0, pos3_ff}) - $signed({1'b0, neg3_ff});
         ma4_ff   <= ma3_ff;
         nega4_ff <= nega3_ff;
         f4_ff    <= f3_ff;
      end
   end

   // squared forms and dot product finish here
   logic [SW-1:0]        sq_sh;
   logic signed [DW-1:0] dot_sh;
   logic [CW-1:0]        early_val;
   logic [1:0]           early_st;

   assign sq_sh  = sum4_ff >> FB;
   assign dot_sh = diff4_ff >>> FB;

   always_comb begin
      early_val = '0;
      early_st  = ST_OK;
      case (func_type'(f4_ff)) inside
         FN_LENGTH_SQ, FN_DISTANCE_SQ: begin
            if (sq_sh > SW'(POS_MAX)) begin
               early_val = POS_MAX;
               early_st  = ST_SAT;
            end else begin
               early_val = sq_sh[CW-1:0];
            end
         end
         FN_DOT: begin
            if (dot_sh > $signed({{(DW-CW){1'b0}}, POS_MAX})) begin
               early_val = POS_MAX;
               early_st  = ST_SAT;
            end else if (dot_sh < $signed({{(DW-CW){1'b1}}, NEG_MIN})) begin
               early_val = NEG_MIN;
               early_st  = ST_SAT;
            end else begin
               early_val = dot_sh[CW-1:0];
            end
         end
         default: begin
            early_val = '0;
            early_st  = ST_OK;
         end
      endcase
   end

   // ---------------- square root ----------------
   logic [SIDE_W-1:0] sq_side_in, sq_side;
   logic [RW-1:0]     root;
   logic              sq_valid;

   assign sq_side_in = {f4_ff, early_val, early_st,
                        ma4_ff[0], ma4_ff[1], ma4_ff[2], ma4_ff[3], nega4_ff};

   vnd_sqrt #(.SW(SW), .RW(RW), .SIDE_W(SIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_sum    (sum4_ff),
      .in_side   (sq_side_in),
      .out_valid (sq_valid),
      .out_root  (root),
      .out_side  (sq_side)
   );

   logic [CW-1:0]    s_ma [LANES];
   logic [2:0]       s_func;
   logic [CW-1:0]    s_early;
   logic [1:0]       s_st;
   logic [LANES-1:0] s_neg;

   assign {s_func, s_early, s_st, s_ma[0], s_ma[1], s_ma[2], s_ma[3], s_neg} = sq_side;

   // ---------------- division lanes ----------------
   logic [QW-1:0] quo [LANES];

   for (genvar i = 0; i < LANES; i++) begin : g_div
      vnd_div #(.RW(RW), .MAGW(CW), .FB(FB)) u_div (
         .clock  (clock),
         .adv    (adv),
         .in_mag (s_ma[i]),
         .in_len (root),
         .out_q  (quo[i])
      );
   end

   // sideband matched to the divider latency
   logic [LINE_W-1:0] line_ff [0:DLAT-1];
   logic [DLAT-1:0]   line_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_vld_ff <= '0;
      end else if (adv) begin
         line_vld_ff <= {line_vld_ff[DLAT-2:0], sq_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         line_ff[0] <= {s_func, s_early, s_st, s_neg, root};
         for (int k = 1; k < DLAT; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end
   end

   logic [2:0]       e_func;
   logic [CW-1:0]    e_early;
   logic [1:0]       e_st;
   logic [LANES-1:0] e_neg;
   logic [RW-1:0]    e_root;

   assign {e_func, e_early, e_st, e_neg, e_root} = line_ff[DLAT-1];

   // ---------------- final select ----------------
   logic [CW-1:0] scalar_in;
   logic [CW-1:0] comp_in [LANES];
   logic [1:0]    status_in;
   logic [CW-1:0] lim;
   logic [CW-1:0] cv;

   always_comb begin
      scalar_in = '0;
      status_in = ST_OK;
      lim       = '0;
      cv        = '0;
      for (int i = 0; i < LANES; i++) begin
         comp_in[i] = '0;
      end
      case (func_type'(e_func)) inside
         FN_LENGTH, FN_DISTANCE: begin
            if (e_root > RW'(POS_MAX)) begin
               scalar_in = POS_MAX;
               status_in = ST_SAT;
            end else begin
               scalar_in = e_root[CW-1:0];
            end
         end
         FN_LENGTH_SQ, FN_DISTANCE_SQ, FN_DOT: begin
            scalar_in = e_early;
            status_in = e_st;
         end
         FN_NORMALISE: begin
            if (e_root == '0) begin
               status_in = ST_ZERO;
            end else begin
               for (int i = 0; i < LANES; i++) begin
                  lim = e_neg[i] ? NEG_MIN : POS_MAX;
                  if (CMPW'(quo[i]) > CMPW'(lim)) begin
                     cv        = lim;
                     status_in = ST_SAT;
                  end else begin
                     cv = CW'(quo[i]);
                  end
                  comp_in[i] = e_neg[i] ? (~cv + 1'b1) : cv;
               end
            end
         end
         default: begin
            scalar_in = '0;
            status_in = ST_OK;
         end
      endcase
   end

   // ---------------- output register ----------------
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] scalar_ff;
   logic [CW-1:0] comp_ff [LANES];
   logic [1:0]    status_ff;

   assign adv          = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = adv ? line_vld_ff[DLAT-1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         scalar_ff <= scalar_in;
         comp_ff   <= comp_in;
         status_ff <= status_in;
      end
   end

   assign req_ready      = adv;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scalar_out = scalar_ff;
   assign rsp_r_x        = comp_ff[0];
   assign rsp_r_y        = comp_ff[1];
   assign rsp_r_z        = comp_ff[2];
   assign rsp_r_w        = comp_ff[3];
   assign rsp_status     = status_ff;

   // ---------------- assertions ----------------
   a_zero_len_clear : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ZERO) |->
         (rsp_scalar_out == '0) && (rsp_r_x == '0) && (rsp_r_y == '0) &&
         (rsp_r_z == '0) && (rsp_r_w == '0))
      else $error("zero-length normalize result carries nonzero data");

   a_vec_excl_scalar : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_r_x != '0) || (rsp_r_y != '0) || (rsp_r_z != '0) ||
                    (rsp_r_w != '0)) |-> (rsp_scalar_out == '0))
      else $error("vector and scalar results both nonzero");

   a_reset_flush : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ----- sim/tb_vec4_norm_dot_normalise.sv -----
`timescale 1ns / 100ps

module tb_vec4_norm_dot_normalise;
   import vnd_pkg::*;

   localparam int CW = 32;
   localparam int FB = 16;
   localparam int LATENCY = CW + FB + 10;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 1000;
   localparam logic [2:0] FN_UNUSED6 = 3'd6;
   localparam logic [2:0] FN_UNUSED7 = 3'd7;
   localparam logic signed [31:0] QMAX = 32'sh7fffffff;
   localparam logic signed [31:0] QMIN = 32'sh80000000;
   localparam logic signed [31:0] ONE = 32'sh00010000;

   typedef struct packed {
      logic [2:0] func;
      logic signed [31:0] ax, ay, az, aw, bx, by, bz, bw;
   } vec_op_type;

   typedef struct packed {
      logic signed [31:0] scalar, rx, ry, rz, rw;
      logic [1:0] status;
   } vec_res_type;

   typedef struct {
      vec_op_type op;
      bit has_exp;
      vec_res_type exp;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_func = '0;
   logic signed [31:0] req_a_x = 0, req_a_y = 0, req_a_z = 0, req_a_w = 0;
   logic signed [31:0] req_b_x = 0, req_b_y = 0, req_b_z = 0, req_b_w = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_scalar_out, rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w;
   logic [1:0] rsp_status;

   vec_res_type pending_results[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int rx_gap = 0;
   bit stim_done = 0;
   bit rx_hold = 0;

   always #1 clock = ~clock;

   vec4_norm_dot_normalise u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z), .req_a_w(req_a_w),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z), .req_b_w(req_b_w),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_scalar_out(rsp_scalar_out),
      .rsp_r_x(rsp_r_x), .rsp_r_y(rsp_r_y), .rsp_r_z(rsp_r_z), .rsp_r_w(rsp_r_w),
      .rsp_status(rsp_status)
   );

   function automatic logic [63:0] isqrt128(logic [127:0] s);
      logic [63:0] r, c;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= s) r = c;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] clamp_q(logic [127:0] m, bit neg,
                                                  inout logic [1:0] st);
      logic [127:0] lim;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (m > lim) begin
         m = lim;
         st = ST_SAT;
      end
      return neg ? -$signed(m[31:0]) : m[31:0];
   endfunction

   function automatic vec_res_type vector_unit(vec_op_type op);
      vec_res_type r;
      logic signed [63:0] a[4], b[4], d[4];
      logic [127:0] sa, sd, pos, neg, q, mag_a;
      logic [63:0] len;
      logic [1:0] st;
      r = '0;
      st = ST_OK;
      a = '{64'(op.ax), 64'(op.ay), 64'(op.az), 64'(op.aw)};
      b = '{64'(op.bx), 64'(op.by), 64'(op.bz), 64'(op.bw)};
      sa = 0; sd = 0; pos = 0; neg = 0;
      for (int i = 0; i < 4; i++) begin
         d[i] = a[i] - b[i];
         sa += 128'(a[i] < 0 ? -a[i] : a[i]) * 128'(a[i] < 0 ? -a[i] : a[i]);
         sd += 128'(d[i] < 0 ? -d[i] : d[i]) * 128'(d[i] < 0 ? -d[i] : d[i]);
         q = 128'(a[i] < 0 ? -a[i] : a[i]) * 128'(b[i] < 0 ? -b[i] : b[i]);
         if ((a[i] < 0) != (b[i] < 0)) neg += q;
         else pos += q;
      end
      case (op.func)
         FN_LENGTH:      r.scalar = clamp_q({64'd0, isqrt128(sa)}, 0, st);
         FN_LENGTH_SQ:   r.scalar = clamp_q(sa >> FB, 0, st);
         FN_DISTANCE:    r.scalar = clamp_q({64'd0, isqrt128(sd)}, 0, st);
         FN_DISTANCE_SQ: r.scalar = clamp_q(sd >> FB, 0, st);
         FN_DOT: begin
            if (pos >= neg) r.scalar = clamp_q((pos - neg) >> FB, 0, st);
            else r.scalar = clamp_q((neg - pos + (1 << FB) - 1) >> FB, 1, st);
         end
         FN_NORMALISE: begin
            len = isqrt128(sa);
            if (len == 0) st = ST_ZERO;
            else begin
               logic signed [31:0] c[4];
               for (int i = 0; i < 4; i++) begin
                  mag_a = 128'(a[i] < 0 ? -a[i] : a[i]);
                  q = (mag_a << FB) / {64'd0, len};
                  c[i] = clamp_q(q, a[i] < 0, st);
               end
               {r.rx, r.ry, r.rz, r.rw} = {c[0], c[1], c[2], c[3]};
            end
         end
         default: ;
      endcase
      r.status = st;
      return r;
   endfunction

   function automatic vec_op_type mk(logic [2:0] f, logic signed [31:0] ax, ay, az, aw,
                                     bx, by, bz, bw);
      vec_op_type o;
      o = '{f, ax, ay, az, aw, bx, by, bz, bw};
      return o;
   endfunction

   function automatic vec_res_type sc(logic signed [31:0] s, logic [1:0] st);
      vec_res_type r;
      r = '0;
      r.scalar = s;
      r.status = st;
      return r;
   endfunction

   function automatic logic signed [31:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
         2: return $urandom_range(0, 1) ? QMAX : QMIN;
         3: return 0;
         default: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
      endcase
   endfunction

   // valid stays high across back-to-back transactions; it drops only for a gap
   task automatic send_op(vec_op_type op, bit has_exp, vec_res_type exp);
      vec_res_type pred;
      int gap;
      gap = $urandom_range(0, 9) < 6 ? 0 :
            ($urandom_range(0, 19) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3));
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      {req_func, req_a_x, req_a_y, req_a_z, req_a_w,
       req_b_x, req_b_y, req_b_z, req_b_w} <= op;
      do @(posedge clock); while (!req_ready);
      pred = vector_unit(op);
      pending_results.push_back(has_exp ? exp : pred);
      if (has_exp && exp !== pred) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("table row mismatch for %h: exp %h predicted %h", op, exp, pred);
      end
   endtask

   initial begin
      stim_row_type rows[$];
      vec_op_type op;
      repeat (12) @(posedge clock);
      reset <= 0;
      rows.push_back('{mk(FN_LENGTH, 0, 0, 0, 0, 0, 0, 0, 0), 1, sc(0, ST_OK)});
      rows.push_back('{mk(FN_LENGTH, ONE, 0, 0, 0, 0, 0, 0, 0), 1, sc(ONE, ST_OK)});
      rows.push_back('{mk(FN_LENGTH, QMIN, QMIN, QMIN, QMIN, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(FN_LENGTH_SQ, QMAX, QMAX, QMAX, QMAX, 0, 0, 0, 0), 1,
                       sc(QMAX, ST_SAT)});
      rows.push_back('{mk(FN_LENGTH_SQ, ONE, ONE, 0, 0, 0, 0, 0, 0), 1,
                       sc(2 * ONE, ST_OK)});
      rows.push_back('{mk(FN_DISTANCE, QMAX, QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QMIN),
                       0, '0});
      rows.push_back('{mk(FN_DISTANCE, ONE, 0, 0, 0, ONE, 0, 0, 0), 1, sc(0, ST_OK)});
      rows.push_back('{mk(FN_DISTANCE_SQ, QMAX, 0, 0, 0, QMIN, 0, 0, 0), 1,
                       sc(QMAX, ST_SAT)});
      rows.push_back('{mk(FN_DOT, QMAX, 0, 0, 0, QMAX, 0, 0, 0), 1, sc(QMAX, ST_SAT)});
      rows.push_back('{mk(FN_DOT, QMAX, 0, 0, 0, QMIN, 0, 0, 0), 1, sc(QMIN, ST_SAT)});
      rows.push_back('{mk(FN_DOT, ONE, ONE, 0, 0, ONE, -ONE, 0, 0), 1, sc(0, ST_OK)});
      rows.push_back('{mk(FN_DOT, -1, 0, 0, 0, 1, 0, 0, 0), 1, sc(-1, ST_OK)});
      rows.push_back('{mk(FN_NORMALISE, 0, 0, 0, 0, 5, 5, 5, 5), 1, sc(0, ST_ZERO)});
      rows.push_back('{mk(FN_NORMALISE, QMIN, 0, 0, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(FN_NORMALISE, 1, -1, 1, -1, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(FN_NORMALISE, QMAX, QMIN, QMAX, QMIN, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mk(FN_UNUSED6, QMAX, 1, 2, 3, 4, 5, 6, 7), 1, sc(0, ST_OK)});
      rows.push_back('{mk(FN_UNUSED7, QMIN, -1, -1, -1, -1, -1, -1, -1), 1, sc(0, ST_OK)});
      foreach (rows[i]) send_op(rows[i].op, rows[i].has_exp, rows[i].exp);
      for (int n = 0; n < N_RANDOM; n++) begin
         op = mk(3'($urandom_range(0, 9) == 0 ? $urandom_range(6, 7) : $urandom_range(0, 5)),
                 rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                 rand_comp(), rand_comp(), rand_comp(), rand_comp());
         send_op(op, 0, '0);
      end
      req_valid <= 0;
      stim_done <= 1;
   end

   // long receiver hold-off so the pipeline fills and back-pressures the sender
   initial begin
      wait (!reset);
      repeat (400) @(posedge clock);
      rx_hold <= 1;
      repeat (300) @(posedge clock);
      rx_hold <= 0;
   end

   always @(posedge clock) begin
      if (reset || rx_hold) rsp_ready <= 0;
      else if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         rsp_ready <= 0;
      end else if ($urandom_range(0, 199) == 0) begin
         rx_gap <= $urandom_range(10, 40);
         rsp_ready <= 0;
      end else if ($urandom_range(0, 9) < 7) rsp_ready <= 1;
      else rsp_ready <= ($urandom_range(0, 30) == 0) ? 1'b0 : 1'($urandom_range(0, 1));
   end

   always @(posedge clock) begin
      vec_res_type got, exp;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_scalar_out, rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w, rsp_status};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected transaction %h", got);
         end else begin
            exp = pending_results.pop_front();
            if (got !== exp) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp s=%h r=%h %h %h %h st=%0d got s=%h r=%h %h %h %h st=%0d",
                           exp.scalar, exp.rx, exp.ry, exp.rz, exp.rw, exp.status,
                           got.scalar, got.rx, got.ry, got.rz, got.rw, got.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      wait (pending_results.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
